// ===== hw/rtl/lpl_pkg.sv =====
package lpl_pkg;

  // field widths
  localparam int SAMPLE_WIDTH   = 24;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int SAMPLE_FRAC    = SAMPLE_WIDTH - 3;
  localparam int CEIL_W         = SAMPLE_WIDTH - 2;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // fixed-point constants
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_ONE = SAMPLE_WIDTH'(1) << SAMPLE_FRAC;
  localparam logic [CEIL_W-1:0]       CEIL_MAX   = CEIL_W'(1) << SAMPLE_FRAC;
  localparam logic [CEIL_W-1:0]       CEIL_MIN   = CEIL_W'((1 << SAMPLE_FRAC) / 10);
  localparam logic [GAIN_W-1:0]       GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0]       STEP_RESET = GAIN_W'(6991);

  // serial unit lengths
  localparam int DIV_STEPS = GAIN_FRAC_BITS;
  localparam int MUL_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CEILING = 2'd0,
    REG_RELEASE = 2'd1,
    REG_LINKED  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic gain_bit;
  } mul_ctl_t;

endpackage

// ===== hw/rtl/lpl_ifs.sv =====
interface lpl_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [lpl_pkg::SAMPLE_WIDTH-1:0]   left_sample;
  logic signed [lpl_pkg::SAMPLE_WIDTH-1:0]   right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface lpl_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [lpl_pkg::SAMPLE_WIDTH-1:0]   left_out;
  logic signed [lpl_pkg::SAMPLE_WIDTH-1:0]   right_out;
  logic                                      over_ceiling;
  logic                                      left_saturated;
  logic                                      right_saturated;
  logic        [lpl_pkg::GAIN_W-1:0]         applied_gain;

  modport source (output valid, left_out, right_out, over_ceiling, left_saturated,
                  right_saturated, applied_gain, input ready);
  modport sink   (input valid, left_out, right_out, over_ceiling, left_saturated,
                  right_saturated, applied_gain, output ready);
endinterface

interface lpl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpl_pkg::CFG_IDX_W-1:0]      index;
  logic [lpl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/linked_peak_limiter.sv =====
// linked peak limiter, instant attack and linear release
//
// samples: one stereo frame per item, left and right in signed q3.21.
// results: one item per frame with the scaled samples, the over-ceiling
//   flag, the two saturation flags and the q1.24 gain that was applied.
// cfg: register writes (0 ceiling, 1 release step, 2 linked stereo), ready
//   whenever out of reset; write only while no frame is in flight.
//
// sequence: a frame whose peak is over the ceiling runs from accept through
//   the bit-serial divider, the gain update, the bit-serial multipliers and
//   the load of the output register; frames under the ceiling skip the
//   divider. one frame is in the datapath at a time, so the next frame is
//   accepted only in the idle state after the last one has been loaded.
//
// reset: samples and cfg are held off; registers return to ceiling 1.0,
//   step 6991, linked stereo, the gain state to 1.0; the result register empties.
// back-pressure: a finished result waits in the output register; the next
//   frame is still accepted and runs, and only its final load waits.
module linked_peak_limiter (
  input logic      clk,
  input logic      rst,
  lpl_in_if.sink   samples,
  lpl_out_if.source results,
  lpl_cfg_if.sink  cfg
);
  import lpl_pkg::*;

  // configuration registers
  logic [CEIL_W-1:0]   ceiling_level;
  logic [GAIN_W-1:0]   release_step;
  logic                linked_stereo;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_level <= CEIL_MAX;
      release_step  <= STEP_RESET;
      linked_stereo <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_CEILING: ceiling_level <= cfg.data[CEIL_W-1:0];
        REG_RELEASE: release_step  <= cfg.data[GAIN_W-1:0];
        REG_LINKED:  linked_stereo <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // clamped register views
  logic [CEIL_W-1:0]   ceil_c;
  logic [GAIN_W-1:0]   step_c;

  always_comb begin
    ceil_c = ceiling_level;
    if (ceiling_level < CEIL_MIN) ceil_c = CEIL_MIN;
    if (ceiling_level > CEIL_MAX) ceil_c = CEIL_MAX;
    step_c = release_step;
    if (release_step == '0)      step_c = GAIN_W'(1);
    if (release_step > GAIN_ONE) step_c = GAIN_ONE;
  end

  // front end: magnitudes and peak of the arriving frame
  logic [SAMPLE_WIDTH-1:0]   lmag_c, rmag_c, peak_c;
  logic                      over_c;

  assign lmag_c = samples.left_sample[SAMPLE_WIDTH-1]
                ? SAMPLE_WIDTH'(-samples.left_sample) : samples.left_sample;
  assign rmag_c = samples.right_sample[SAMPLE_WIDTH-1]
                ? SAMPLE_WIDTH'(-samples.right_sample) : samples.right_sample;
  assign peak_c = (linked_stereo && rmag_c > lmag_c) ? rmag_c : lmag_c;
  assign over_c = peak_c > SAMPLE_WIDTH'(ceil_c);

  // frame registers
  logic [SAMPLE_WIDTH-1:0]   lmag, rmag;
  logic                      lneg, rneg;
  logic                      over;
  logic                      stereo;
  logic                      take;

  assign take = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (take) begin
      lmag   <= lmag_c;
      rmag   <= rmag_c;
      lneg   <= samples.left_sample[SAMPLE_WIDTH-1];
      rneg   <= samples.right_sample[SAMPLE_WIDTH-1];
      over   <= over_c;
      stereo <= linked_stereo;
    end
  end

  // control
  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt;
  div_ctl_t            div_ctl;
  mul_ctl_t            mul_ctl;
  logic                gain_load;
  logic                out_load;
  logic [GAIN_W-1:0]   gain_sr;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = over_c ? ST_DIV : ST_GAIN;
      ST_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_GAIN;
      ST_GAIN: state_next = ST_MUL;
      ST_MUL:  if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: if (!results.valid || results.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready    = 1'b0;
    div_ctl          = '0;
    mul_ctl          = '0;
    gain_load        = 1'b0;
    out_load         = 1'b0;
    mul_ctl.gain_bit = gain_sr[0];
    case (state)
      ST_IDLE: begin
        samples.ready = !rst;
        div_ctl.load  = samples.valid;
      end
      ST_DIV:  div_ctl.step = 1'b1;
      ST_GAIN: begin
        gain_load    = 1'b1;
        mul_ctl.load = 1'b1;
      end
      ST_MUL:  mul_ctl.step = 1'b1;
      ST_DONE: out_load = !results.valid || results.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else                     cnt <= cnt + CNT_W'(1);
    end
  end

  // target gain divider
  logic [GAIN_FRAC_BITS-1:0] quotient;

  lpl_divider u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (ceil_c),
    .divisor  (peak_c),
    .quotient (quotient)
  );

  // gain update: attack at once, release by the step up to unity
  logic [GAIN_W-1:0]   gain_state;
  logic [GAIN_W-1:0]   target;
  logic [GAIN_W:0]     raised;
  logic [GAIN_W-1:0]   gain_next;

  assign target = over ? GAIN_W'(quotient) : GAIN_ONE;
  assign raised = {1'b0, gain_state} + {1'b0, step_c};

  always_comb begin
    if (target < gain_state)                   gain_next = target;
    else if (raised > (GAIN_W + 1)'(GAIN_ONE)) gain_next = GAIN_ONE;
    else                                       gain_next = raised[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_state <= GAIN_ONE;
    end else if (gain_load) begin
      gain_state <= gain_next;
    end
  end

  // gain bits feed both multipliers lsb first
  always_ff @(posedge clk) begin
    if (gain_load)         gain_sr <= gain_next;
    else if (mul_ctl.step) gain_sr <= {1'b0, gain_sr[GAIN_W-1:1]};
  end

  // scaling, one multiplier per channel
  logic signed [SAMPLE_WIDTH-1:0] lval, rval;
  logic                           lsat, rsat;

  lpl_mult u_mul_left (
    .clk   (clk),
    .ctl   (mul_ctl),
    .mag   (lmag),
    .neg   (lneg),
    .value (lval),
    .sat   (lsat)
  );

  lpl_mult u_mul_right (
    .clk   (clk),
    .ctl   (mul_ctl),
    .mag   (rmag),
    .neg   (rneg),
    .value (rval),
    .sat   (rsat)
  );

  // output register, right channel forced quiet in mono mode
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.left_out        <= lval;
      results.right_out       <= stereo ? rval : '0;
      results.over_ceiling    <= over;
      results.left_saturated  <= lsat;
      results.right_saturated <= stereo && rsat;
      results.applied_gain    <= gain_state;
    end
  end

endmodule

// ===== hw/rtl/lpl_divider.sv =====
module lpl_divider (
  input  logic                                 clk,
  input  lpl_pkg::div_ctl_t                    ctl,
  input  logic [lpl_pkg::CEIL_W-1:0]           dividend,
  input  logic [lpl_pkg::SAMPLE_WIDTH-1:0]     divisor,
  output logic [lpl_pkg::GAIN_FRAC_BITS-1:0]   quotient
);
  import lpl_pkg::*;

  // restoring division, one quotient bit per cycle, msb first
  logic [SAMPLE_WIDTH-1:0]   rem;
  logic [SAMPLE_WIDTH-1:0]   dsr;
  logic [SAMPLE_WIDTH:0]     rem_sh;
  logic                      fits;

  assign rem_sh = {rem, 1'b0};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem      <= SAMPLE_WIDTH'(dividend);
      dsr      <= divisor;
      quotient <= '0;
    end else if (ctl.step) begin
      rem      <= fits ? SAMPLE_WIDTH'(rem_sh - {1'b0, dsr}) : rem_sh[SAMPLE_WIDTH-1:0];
      quotient <= {quotient[GAIN_FRAC_BITS-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/lpl_mult.sv =====
module lpl_mult (
  input  logic                                     clk,
  input  lpl_pkg::mul_ctl_t                        ctl,
  input  logic [lpl_pkg::SAMPLE_WIDTH-1:0]         mag,
  input  logic                                     neg,
  output logic signed [lpl_pkg::SAMPLE_WIDTH-1:0]  value,
  output logic                                     sat
);
  import lpl_pkg::*;

  // shift-add over gain bits, lsb first; low product bits shift out into lo
  logic [SAMPLE_WIDTH-1:0]   hi;
  logic [GAIN_W-1:0]         lo;
  logic [SAMPLE_WIDTH:0]     sum;
  logic [SAMPLE_WIDTH-1:0]   trunc;
  logic [SAMPLE_WIDTH-1:0]   rounded;

  assign sum = {1'b0, hi} + (ctl.gain_bit ? {1'b0, mag} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hi <= '0;
      lo <= '0;
    end else if (ctl.step) begin
      hi <= sum[SAMPLE_WIDTH:1];
      lo <= {sum[0], lo[GAIN_W-1:1]};
    end
  end

  // round half away from zero on the magnitude, then restore the sign
  assign trunc   = {hi[SAMPLE_WIDTH-2:0], lo[GAIN_W-1]};
  assign rounded = trunc + SAMPLE_WIDTH'(lo[GAIN_W-2]);
  assign sat     = rounded > SAMPLE_ONE;
  assign value   = neg ? SAMPLE_WIDTH'(-rounded) : rounded;

endmodule
